FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic signed [31:0]  item_value;
        logic signed [15:0]  item_priority;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0]  out_value;
        logic signed [15:0]  out_priority;
        logic [1:0]          status;
        logic [4:0]          occupancy;
    } t_out_rsp;

    typedef struct packed {
        logic exec_op;
        logic load_rsp;
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction   Handshake                  Payload
// in        request     i_in_valid / o_in_ready    i_in_req  (t_in_req)
// out       response    o_out_valid / i_out_ready  o_out_rsp (t_out_rsp)
//
// Every request is carried out in the cycle it is accepted: on an insert all sixteen cells
// compare against the new priority at once and shift; a remove moves every cell toward the head.
// Its response is registered and is offered from the next cycle on.
// A new request is taken whenever the response register is empty or being drained.
// Reset clears the entry count and the response valid flag; cell contents are not reset.

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_in_req i_in_req,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_out_rsp     o_out_rsp
);

    t_dp_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    spq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in_req),
        .o_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

FILE: src/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    localparam logic S_EMPTY = 1'b0;
    localparam logic S_HOLD  = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    assign o_in_ready  = (r_state == S_EMPTY) || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_HOLD);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EMPTY: begin
                if (w_accept) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_out_ready && !w_accept) begin
                    n_state = S_EMPTY;
                end
            end
            default: begin
                n_state = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.exec_op  = w_accept;
    assign o_cmd.load_rsp = w_accept;

endmodule

`default_nettype wire

FILE: src/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
    import spq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_in_req i_req,
    output t_out_rsp     o_rsp
);

    logic signed [31:0] r_val [CAPACITY];
    logic signed [15:0] r_pri [CAPACITY];
    logic signed [31:0] n_val [CAPACITY];
    logic signed [15:0] n_pri [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CAPACITY-1:0] w_keep;
    logic               w_full;
    logic               w_empty;
    logic               w_is_ins;
    logic               w_is_head;
    t_out_rsp           r_rsp;
    t_out_rsp           n_rsp;

    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_is_ins  = (i_req.op == OP_INSERT);
    assign w_is_head = (i_req.op == OP_REMOVE) || (i_req.op == OP_PEEK);

    // Each cell that holds a priority at least as high as the new one stays put.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_keep[i] = (CNT_W'(i) < r_count) && (r_pri[i] >= i_req.item_priority);
        end
    end

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
        end
        if (w_is_ins && !w_full) begin
            n_count = r_count + 1'b1;
            for (int i = 0; i < CAPACITY; i++) begin
                if (!w_keep[i]) begin
                    if (i == 0) begin
                        n_val[i] = i_req.item_value;
                        n_pri[i] = i_req.item_priority;
                    end else if (w_keep[(i == 0) ? 0 : i - 1]) begin
                        n_val[i] = i_req.item_value;
                        n_pri[i] = i_req.item_priority;
                    end else begin
                        n_val[i] = r_val[(i == 0) ? 0 : i - 1];
                        n_pri[i] = r_pri[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end else if ((i_req.op == OP_REMOVE) && !w_empty) begin
            n_count = r_count - 1'b1;
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_val[i] = r_val[i + 1];
                n_pri[i] = r_pri[i + 1];
            end
        end
    end

    always_comb begin
        n_rsp.out_value    = '0;
        n_rsp.out_priority = '0;
        n_rsp.status       = STAT_OK;
        n_rsp.occupancy    = 5'(n_count);
        if (w_is_ins && w_full) begin
            n_rsp.status = STAT_FULL;
        end else if (w_is_head && w_empty) begin
            n_rsp.status = STAT_EMPTY;
        end else if (w_is_head) begin
            n_rsp.out_value    = r_val[0];
            n_rsp.out_priority = r_pri[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec_op) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_op) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_val[i] <= n_val[i];
                r_pri[i] <= n_pri[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

FILE: test/sorted_priority_queue_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int RANDOM_REQS = 700;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_mix;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_rsp rsp;
    } t_dir_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_in_req  in_req = '0;
    logic     out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_out_rsp o_out_rsp;

    logic signed [31:0] held_value [CAPACITY];
    logic signed [15:0] held_prio [CAPACITY];
    int                 held_count = 0;

    t_out_rsp expected_rsp_q [$];
    t_dir_row dir_rows [$];
    int       send_gap_pct = 6;
    int       rsp_stall_pct = 53;
    int       mismatches = 0;
    int       cycle_count = 0;
    t_mix     op_mix = MODE_FILL;
    int       mix_left = 0;

    sorted_priority_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Applies one request to the held list and returns the response it causes.
    function automatic t_out_rsp predict_queue_op(t_in_req req);
        t_out_rsp rsp;
        int pos;
        int idx;
        rsp = '0;
        case (req.op)
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    rsp.status = STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_prio[pos] >= req.item_priority) pos++;
                    for (idx = held_count; idx > pos; idx--) begin
                        held_value[idx] = held_value[idx - 1];
                        held_prio[idx]  = held_prio[idx - 1];
                    end
                    held_value[pos] = req.item_value;
                    held_prio[pos]  = req.item_priority;
                    held_count++;
                end
            end
            OP_REMOVE, OP_PEEK: begin
                if (held_count == 0) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    rsp.out_value    = held_value[0];
                    rsp.out_priority = held_prio[0];
                    if (req.op == OP_REMOVE) begin
                        for (idx = 1; idx < held_count; idx++) begin
                            held_value[idx - 1] = held_value[idx];
                            held_prio[idx - 1]  = held_prio[idx];
                        end
                        held_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.occupancy = 5'(held_count);
        return rsp;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [31:0] value, logic [15:0] prio,
                                    bit typed, logic [31:0] exp_value = '0,
                                    logic [15:0] exp_prio = '0,
                                    logic [1:0] exp_status = STAT_OK,
                                    logic [4:0] exp_occ = '0);
        t_dir_row row;
        row.req.op            = op;
        row.req.item_value    = value;
        row.req.item_priority = prio;
        row.typed             = typed;
        row.rsp.out_value     = exp_value;
        row.rsp.out_priority  = exp_prio;
        row.rsp.status        = exp_status;
        row.rsp.occupancy     = exp_occ;
        dir_rows.push_back(row);
    endfunction

    function automatic t_in_req random_request();
        t_in_req req;
        int roll;
        int ins_pct;
        int rem_pct;
        if (mix_left == 0) begin
            op_mix   = t_mix'($urandom_range(2));
            mix_left = $urandom_range(15, 50);
        end
        mix_left--;
        case (op_mix)
            MODE_FILL:  begin ins_pct = 70; rem_pct = 15; end
            MODE_DRAIN: begin ins_pct = 25; rem_pct = 55; end
            default:    begin ins_pct = 42; rem_pct = 35; end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct) req.op = OP_INSERT;
        else if (roll < ins_pct + rem_pct) req.op = OP_REMOVE;
        else if (roll < 97) req.op = OP_PEEK;
        else req.op = OP_NOP;
        roll = $urandom_range(99);
        if (roll < 10) req.item_value = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        else req.item_value = $urandom;
        roll = $urandom_range(99);
        if (roll < 50) begin
            req.item_priority = 16'($signed($urandom_range(6)) - 3);
        end else if (roll < 80) begin
            req.item_priority = 16'($urandom);
        end else begin
            case ($urandom_range(3))
                0: req.item_priority = 16'h8000;
                1: req.item_priority = 16'h7fff;
                2: req.item_priority = 16'h0000;
                default: req.item_priority = 16'hffff;
            endcase
        end
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_in_req req, input bit typed, input t_out_rsp typed_rsp);
        t_out_rsp predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_queue_op(req);
        expected_rsp_q.push_back(typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_rsp exp_rsp;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_rsp_q.size() == 0) begin
                $error("response with none expected: %p", o_out_rsp);
                mismatches++;
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                if (o_out_rsp.out_value !== exp_rsp.out_value) begin
                    $error("out_value: expected %0d, actual %0d",
                           exp_rsp.out_value, o_out_rsp.out_value);
                    mismatches++;
                end
                if (o_out_rsp.out_priority !== exp_rsp.out_priority) begin
                    $error("out_priority: expected %0d, actual %0d",
                           exp_rsp.out_priority, o_out_rsp.out_priority);
                    mismatches++;
                end
                if (o_out_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d",
                           exp_rsp.status, o_out_rsp.status);
                    mismatches++;
                end
                if (o_out_rsp.occupancy !== exp_rsp.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           exp_rsp.occupancy, o_out_rsp.occupancy);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [15:0] fill_prio [13];
        logic [31:0] fill_value [13];
        int n;
        fill_prio  = '{16'h0000, 16'hffff, 16'h0001, 16'h0000, 16'h8000, 16'h7fff, 16'h0005,
                       16'hfffb, 16'h0000, 16'h0100, 16'hff00, 16'h0001, 16'hffff};
        fill_value = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555,
                       32'haaaa_aaaa, 32'h0000_0002, 32'h0000_0003, 32'h1234_5678, 32'hdead_beef,
                       32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0004};

        // Empty queue, unused op code, then the value and priority extremes.
        add_row(OP_PEEK,   32'hffff_ffff, 16'hffff, 1'b1, '0, '0, STAT_EMPTY, 5'd0);
        add_row(OP_REMOVE, 32'hffff_ffff, 16'hffff, 1'b1, '0, '0, STAT_EMPTY, 5'd0);
        add_row(OP_NOP,    32'h0000_0000, 16'h0000, 1'b1, '0, '0, STAT_OK, 5'd0);
        add_row(OP_INSERT, 32'h7fff_ffff, 16'h7fff, 1'b1, '0, '0, STAT_OK, 5'd1);
        add_row(OP_INSERT, 32'h8000_0000, 16'h8000, 1'b1, '0, '0, STAT_OK, 5'd2);
        add_row(OP_PEEK,   32'h0000_0000, 16'h0000, 1'b1, 32'h7fff_ffff, 16'h7fff, STAT_OK, 5'd2);
        add_row(OP_INSERT, 32'h0000_0001, 16'h7fff, 1'b0);
        // Fill up with ties and mixed signs.
        for (n = 0; n < 13; n++) add_row(OP_INSERT, fill_value[n], fill_prio[n], 1'b0);
        add_row(OP_INSERT, 32'h1111_1111, 16'h7fff, 1'b1, '0, '0, STAT_FULL, 5'd16);
        add_row(OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, 32'h7fff_ffff, 16'h7fff, STAT_OK, 5'd15);
        add_row(OP_PEEK,   32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0001, 16'h7fff, STAT_OK, 5'd15);
        add_row(OP_NOP,    32'hffff_ffff, 16'hffff, 1'b1, '0, '0, STAT_OK, 5'd15);
        add_row(OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b0);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);

        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 3) begin
                send_gap_pct  = 53;
                rsp_stall_pct = 6;
            end else if (n == 2 * RANDOM_REQS / 3) begin
                send_gap_pct  = 0;
                rsp_stall_pct = 0;
            end
            send_request(random_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_rsp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
